@@ sv/arithmetic_encoder_core_assert.svh @@
// ----------------------------------------------------------------------------
// arithmetic_encoder_core_assert.svh
// assertion macros used by the arithmetic encoder datapath
// ----------------------------------------------------------------------------
`ifndef ARITHMETIC_ENCODER_CORE_ASSERT_SVH
`define ARITHMETIC_ENCODER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AEC_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define AEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define AEC_ASSERT(label, expr, msg)
`define AEC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ sv/aec_pkg.sv @@
// ----------------------------------------------------------------------------
// aec_pkg
// types and constants of the arithmetic encoder core
// ----------------------------------------------------------------------------
package aec_pkg;

  localparam int CNT_W      = 14;
  localparam int IN_DATA_W  = 48;
  localparam int MAX_BYTES  = 8;
  localparam int BYTE_CNT_W = 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_NARROW,
    ST_RENORM,
    ST_EMIT,
    ST_PEND,
    ST_FIN,
    ST_FLUSH,
    ST_DRAIN
  } aec_state_t;

  typedef struct packed {
    logic capture;
    logic set_range;
    logic load_prod;
    logic div_step;
    logic narrow;
    logic renorm;
    logic fin_pend;
    logic pack;
    logic pack_inv;
    logic flush;
    logic drain;
  } aec_cmd_t;

  typedef struct packed {
    logic bad_sym;
    logic div_done;
    logic narrow_ok;
    logic step_go;
    logic step_emit;
    logic pend_zero;
    logic pend_last;
    logic pack_ok;
    logic flush_ok;
    logic drain_ok;
  } aec_stat_t;

endpackage

@@ sv/aec_ctrl.sv @@
// ----------------------------------------------------------------------------
// aec_ctrl
// sequencer of the arithmetic encoder: scaling, renormalization, flush
// ----------------------------------------------------------------------------
module aec_ctrl
  import aec_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_req_type,
  output logic      in_ready,
  input  aec_stat_t stat,
  output aec_cmd_t  cmd
);

  aec_state_t state;
  aec_state_t state_next;
  logic       fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fin   <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.capture) begin
        fin <= in_req_type;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        if (fin) state_next = ST_FIN;
        else if (stat.bad_sym) state_next = ST_DRAIN;
        else state_next = ST_MUL;
      end
      ST_MUL: state_next = ST_DIV;
      ST_DIV: begin
        if (stat.div_done) state_next = ST_NARROW;
      end
      ST_NARROW: begin
        state_next = stat.narrow_ok ? ST_RENORM : ST_DRAIN;
      end
      ST_RENORM: begin
        if (!stat.step_go) state_next = ST_DRAIN;
        else if (stat.step_emit) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.pack_ok) begin
          if (!stat.pend_zero) state_next = ST_PEND;
          else state_next = fin ? ST_FLUSH : ST_RENORM;
        end
      end
      ST_PEND: begin
        if (stat.pack_ok && stat.pend_last) state_next = fin ? ST_FLUSH : ST_RENORM;
      end
      ST_FIN: state_next = ST_EMIT;
      ST_FLUSH: begin
        if (stat.flush_ok) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (stat.drain_ok) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.capture   = (state == ST_IDLE) && in_valid;
    cmd.set_range = (state == ST_SETUP);
    cmd.load_prod = (state == ST_MUL);
    cmd.div_step  = (state == ST_DIV);
    cmd.narrow    = (state == ST_NARROW) && stat.narrow_ok;
    cmd.renorm    = (state == ST_RENORM) && stat.step_go;
    cmd.fin_pend  = (state == ST_FIN);
    cmd.pack      = (state == ST_EMIT) && stat.pack_ok;
    cmd.pack_inv  = (state == ST_PEND) && stat.pack_ok;
    cmd.flush     = (state == ST_FLUSH) && stat.flush_ok;
    cmd.drain     = (state == ST_DRAIN) && stat.drain_ok;
  end

  assign in_ready = (state == ST_IDLE);

endmodule

@@ sv/aec_datapath.sv @@
// ----------------------------------------------------------------------------
// aec_datapath
// interval registers, bit-serial dividers, bit packer and output stage
// ----------------------------------------------------------------------------
`include "arithmetic_encoder_core_assert.svh"

module aec_datapath
  import aec_pkg::*;
#(
  parameter int CODE_BITS   = 16,
  parameter int FREQ_BITS   = 14,
  parameter int PENDING_MAX = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  aec_cmd_t         cmd,
  output aec_stat_t        stat,
  input  logic [CNT_W-1:0] cum_low,
  input  logic [CNT_W-1:0] cum_high,
  input  logic [CNT_W-1:0] cum_total,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [7:0]       out_data,
  output logic             out_last
);

  localparam int FW     = (FREQ_BITS < CNT_W) ? FREQ_BITS : CNT_W;
  localparam int RW     = CODE_BITS + 1;
  localparam int PROD_W = RW + FW;
  localparam int DCW    = $clog2(PROD_W);
  localparam int SCW    = $clog2(CODE_BITS + 1);
  localparam int PW     = $clog2(PENDING_MAX + 1);

  logic [FW-1:0]         cl, ch, ct;
  logic [RW-1:0]         range_q;
  logic [PROD_W-1:0]     dq_up, dq_dn;
  logic [FW-1:0]         rem_up, rem_dn;
  logic [DCW-1:0]        div_cnt;
  logic [SCW-1:0]        steps;
  logic [CODE_BITS-1:0]  low, high;
  logic [PW-1:0]         pend;
  logic                  emit_bit;
  logic [7:0]            shift_reg;
  logic [2:0]            bits_held;
  logic [7:0]            hold_byte;
  logic                  hold_valid;
  logic [BYTE_CNT_W-1:0] byte_cnt;

  logic [FW:0]     trial_up, trial_dn;
  logic            ge_up, ge_dn;
  logic [RW-1:0]   q_up, q_dn, nhigh_w, nlow_w;
  logic            below, above, mid;
  logic            pb;
  logic [7:0]      packed_byte, flush_byte, cpl_byte;
  logic            cpl, take, out_free, room, push_hold;

  // one quotient bit per cycle for each bound
  assign trial_up = {rem_up, dq_up[PROD_W-1]};
  assign trial_dn = {rem_dn, dq_dn[PROD_W-1]};
  assign ge_up    = trial_up >= {1'b0, ct};
  assign ge_dn    = trial_dn >= {1'b0, ct};

  assign q_up    = dq_up[RW-1:0];
  assign q_dn    = dq_dn[RW-1:0];
  assign nhigh_w = {1'b0, low} + q_up - RW'(1);
  assign nlow_w  = {1'b0, low} + q_dn;

  assign below = !high[CODE_BITS-1];
  assign above = low[CODE_BITS-1];
  assign mid   = low[CODE_BITS-2] && !high[CODE_BITS-2];

  assign pb          = cmd.pack_inv ? ~emit_bit : emit_bit;
  assign packed_byte = {pb, shift_reg[7:1]};
  assign flush_byte  = shift_reg >> (4'd8 - {1'b0, bits_held});
  assign cpl_byte    = cmd.flush ? flush_byte : packed_byte;
  assign cpl         = ((cmd.pack || cmd.pack_inv) && (bits_held == 3'd7)) ||
                       (cmd.flush && (bits_held != 3'd0));
  assign take        = cpl && (byte_cnt < BYTE_CNT_W'(MAX_BYTES));
  assign out_free    = !out_valid || out_ready;
  assign room        = !hold_valid || out_free || (byte_cnt == BYTE_CNT_W'(MAX_BYTES));
  assign push_hold   = hold_valid && (take || cmd.drain);

  always_comb begin
    stat           = '0;
    stat.bad_sym   = (ct == '0) || (ch <= cl) || (ch > ct);
    stat.div_done  = (div_cnt == DCW'(PROD_W - 1));
    stat.narrow_ok = q_up > q_dn;
    stat.step_go   = (steps != SCW'(CODE_BITS)) && (below || above || mid);
    stat.step_emit = below || above;
    stat.pend_zero = (pend == '0);
    stat.pend_last = (pend == PW'(1));
    stat.pack_ok   = (bits_held != 3'd7) || room;
    stat.flush_ok  = (bits_held == 3'd0) || room;
    stat.drain_ok  = !hold_valid || out_free;
  end

  // capture, scaling and division
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cl <= cum_low[FW-1:0];
      ch <= cum_high[FW-1:0];
      ct <= cum_total[FW-1:0];
    end
    if (cmd.set_range) begin
      range_q <= {1'b0, high} - {1'b0, low} + RW'(1);
    end
    if (cmd.load_prod) begin
      dq_up   <= PROD_W'(range_q) * PROD_W'(ch);
      dq_dn   <= PROD_W'(range_q) * PROD_W'(cl);
      rem_up  <= '0;
      rem_dn  <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem_up  <= ge_up ? FW'(trial_up - {1'b0, ct}) : FW'(trial_up);
      rem_dn  <= ge_dn ? FW'(trial_dn - {1'b0, ct}) : FW'(trial_dn);
      dq_up   <= {dq_up[PROD_W-2:0], ge_up};
      dq_dn   <= {dq_dn[PROD_W-2:0], ge_dn};
      div_cnt <= div_cnt + DCW'(1);
    end
    if (cmd.narrow) begin
      steps <= '0;
    end else if (cmd.renorm) begin
      steps <= steps + SCW'(1);
    end
    if (cmd.renorm && (below || above)) begin
      emit_bit <= above;
    end else if (cmd.fin_pend) begin
      emit_bit <= low[CODE_BITS-1] | low[CODE_BITS-2];
    end
  end

  // interval, pending count and bit packer
  always_ff @(posedge clk) begin
    if (rst) begin
      low       <= '0;
      high      <= '1;
      pend      <= '0;
      shift_reg <= '0;
      bits_held <= '0;
    end else begin
      if (cmd.narrow) begin
        low  <= nlow_w[CODE_BITS-1:0];
        high <= nhigh_w[CODE_BITS-1:0];
      end else if (cmd.renorm) begin
        if (!below && !above) begin
          low  <= {1'b0, low[CODE_BITS-3:0], 1'b0};
          high <= {1'b1, high[CODE_BITS-3:0], 1'b1};
        end else begin
          low  <= {low[CODE_BITS-2:0], 1'b0};
          high <= {high[CODE_BITS-2:0], 1'b1};
        end
      end
      if ((cmd.renorm && !below && !above) || cmd.fin_pend) begin
        if (pend != PW'(PENDING_MAX)) pend <= pend + PW'(1);
      end else if (cmd.pack_inv) begin
        pend <= pend - PW'(1);
      end
      if (cmd.pack || cmd.pack_inv) begin
        if (bits_held == 3'd7) begin
          shift_reg <= '0;
          bits_held <= '0;
        end else begin
          shift_reg <= packed_byte;
          bits_held <= bits_held + 3'd1;
        end
      end
      if (cmd.flush) begin
        low       <= '0;
        high      <= '1;
        pend      <= '0;
        shift_reg <= '0;
        bits_held <= '0;
      end
    end
  end

  // last completed byte waits in hold until its last flag is known
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      byte_cnt   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.capture) begin
        byte_cnt <= '0;
      end else if (take) begin
        byte_cnt <= byte_cnt + BYTE_CNT_W'(1);
      end
      if (take) begin
        hold_valid <= 1'b1;
      end else if (cmd.drain) begin
        hold_valid <= 1'b0;
      end
      if (push_hold) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_byte <= cpl_byte;
    end
    if (push_hold) begin
      out_data <= hold_byte;
      out_last <= cmd.drain;
    end
  end

  `AEC_ASSERT(a_interval_order, low <= high, "interval bounds crossed")
  `AEC_ASSERT(a_pend_bound, pend <= PW'(PENDING_MAX), "pending count above limit")
  `AEC_ASSERT(a_byte_bound, byte_cnt <= BYTE_CNT_W'(MAX_BYTES), "too many bytes for item")
  `AEC_ASSERT_NEXT(a_flush_clears, cmd.flush, (bits_held == 3'd0) && (pend == '0) && (low == '0), "flush left state")
  `AEC_ASSERT_NEXT(a_drain_empties, cmd.drain, !hold_valid, "hold byte kept after drain")

endmodule

@@ sv/arithmetic_encoder_core.sv @@
// ----------------------------------------------------------------------------
// arithmetic_encoder_core
// integer arithmetic encoder, static model per symbol, byte output lsb first
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                   tuser      tlast
//  s_axis   in   [13:0] cum_low [27:14] cum_high         req_type   -
//                [41:28] cum_total, rest zero
//  m_axis   out  [7:0] out_byte                          -          last
//
//  encode item: capture, range setup, product load, the two bit-serial
//  dividers, narrowing, renormalization steps, coded bit output, drain
//  finish item: pending bump, coded bit output, flush, drain
//  reset returns control, interval, pending, packer and hold/output flags at once, no clearing pass
//  a byte stall holds the packer only when hold and output register are full
// ----------------------------------------------------------------------------
module arithmetic_encoder_core
  import aec_pkg::*;
#(
  parameter int CODE_BITS   = 16,
  parameter int FREQ_BITS   = 14,
  parameter int PENDING_MAX = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,  // cum_low, cum_high, cum_total
  input  logic                 s_axis_tuser,  // req_type
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,  // out_byte
  output logic                 m_axis_tlast
);

  aec_cmd_t  cmd;
  aec_stat_t stat;

  aec_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_req_type (s_axis_tuser),
    .in_ready    (s_axis_tready),
    .stat        (stat),
    .cmd         (cmd)
  );

  aec_datapath #(
    .CODE_BITS   (CODE_BITS),
    .FREQ_BITS   (FREQ_BITS),
    .PENDING_MAX (PENDING_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cum_low   (s_axis_tdata[CNT_W-1:0]),
    .cum_high  (s_axis_tdata[2*CNT_W-1:CNT_W]),
    .cum_total (s_axis_tdata[3*CNT_W-1:2*CNT_W]),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

@@ dv/tb_arithmetic_encoder_core.sv @@
// ----------------------------------------------------------------------------
// tb_arithmetic_encoder_core
// self-checking bench for the arithmetic encoder core: a directed table
// (reset, bad symbols, interval extremes, pending saturation, finish) and
// random symbol streams closed by finish items. Every accepted untyped item
// runs through a bit-exact encoder model that queues the code bytes it
// produces. The sender works in bursts and the receiver stalls in phases.
// ----------------------------------------------------------------------------
module tb_arithmetic_encoder_core
  import aec_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CODE_W     = 16;
  localparam int unsigned PEND_MAX   = 32;
  localparam logic [16:0] TOP_VAL    = 17'h0FFFF;
  localparam logic [16:0] HALF_VAL   = 17'h08000;
  localparam logic [16:0] QTR_VAL    = 17'h04000;
  localparam logic [16:0] TQTR_VAL   = 17'h0C000;
  localparam int          RAND_ITEMS = 420;
  localparam int          DRAIN_CYC  = 400;
  localparam int          CYCLE_CAP  = 800000;
  localparam int          N_DIR      = 24;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } code_byte_t;

  typedef struct packed {
    logic        fin;
    logic [13:0] cl;
    logic [13:0] ch;
    logic [13:0] ct;
    logic        typed;
    logic        has_byte;
    logic [7:0]  byte_val;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [7:0]           m_axis_tdata;
  logic                 m_axis_tlast;

  logic [16:0]  iv_low;
  logic [16:0]  iv_high;
  int unsigned  pend_cnt;
  logic [7:0]   code_sr;
  int unsigned  code_held;
  logic [7:0]   item_bytes[$];
  code_byte_t   coded_q[$];

  int mismatches = 0;
  int cycles     = 0;
  int burst_left = 0;
  int rx_left    = 0;
  int rx_mode    = 0;

  stim_row_t dir_tab [N_DIR] = '{
    '{1'b1, 14'd0,     14'd0,     14'd0,     1'b1, 1'b1, 8'h02},
    '{1'b0, 14'd0,     14'd1,     14'd0,     1'b1, 1'b0, 8'h00},
    '{1'b0, 14'd5,     14'd5,     14'd10,    1'b1, 1'b0, 8'h00},
    '{1'b0, 14'd0,     14'd11,    14'd10,    1'b1, 1'b0, 8'h00},
    '{1'b0, 14'h3FFF,  14'h3FFF,  14'h3FFF,  1'b1, 1'b0, 8'h00},
    '{1'b0, 14'd0,     14'h3FFF,  14'h3FFF,  1'b0, 1'b0, 8'h00},
    '{1'b0, 14'd0,     14'd1,     14'h3FFF,  1'b0, 1'b0, 8'h00},
    '{1'b0, 14'h3FFE,  14'h3FFF,  14'h3FFF,  1'b0, 1'b0, 8'h00},
    '{1'b0, 14'd8191,  14'd8192,  14'd16383, 1'b0, 1'b0, 8'h00},
    '{1'b0, 14'd8191,  14'd8192,  14'd16383, 1'b0, 1'b0, 8'h00},
    '{1'b0, 14'd8191,  14'd8192,  14'd16383, 1'b0, 1'b0, 8'h00},
    '{1'b0, 14'd8191,  14'd8192,  14'd16383, 1'b0, 1'b0, 8'h00},
    '{1'b1, 14'h3FFF,  14'h3FFF,  14'h3FFF,  1'b0, 1'b0, 8'h00},
    '{1'b0, 14'd0,     14'd1,     14'd1,     1'b0, 1'b0, 8'h00},
    '{1'b0, 14'd0,     14'd1,     14'd2,     1'b0, 1'b0, 8'h00},
    '{1'b0, 14'd1,     14'd2,     14'd2,     1'b0, 1'b0, 8'h00},
    '{1'b0, 14'd1,     14'd2,     14'd3,     1'b0, 1'b0, 8'h00},
    '{1'b1, 14'd0,     14'd0,     14'd0,     1'b0, 1'b0, 8'h00},
    '{1'b0, 14'd0,     14'd1,     14'h3FFF,  1'b0, 1'b0, 8'h00},
    '{1'b0, 14'd0,     14'd1,     14'h3FFF,  1'b0, 1'b0, 8'h00},
    '{1'b1, 14'd0,     14'd0,     14'd0,     1'b0, 1'b0, 8'h00},
    '{1'b1, 14'h2AAA,  14'h1555,  14'h3FFF,  1'b1, 1'b1, 8'h02},
    '{1'b0, 14'h1555,  14'h2AAA,  14'h3FFF,  1'b0, 1'b0, 8'h00},
    '{1'b1, 14'd0,     14'd0,     14'd0,     1'b0, 1'b0, 8'h00}
  };

  arithmetic_encoder_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk = ~clk;

  function automatic void reset_model();
    iv_low    = '0;
    iv_high   = TOP_VAL;
    pend_cnt  = 0;
    code_sr   = '0;
    code_held = 0;
  endfunction

  function automatic void put_code_byte(logic [7:0] b);
    if (item_bytes.size() < MAX_BYTES) item_bytes.push_back(b);
  endfunction

  function automatic void shift_bit(bit b);
    code_sr = {b, code_sr[7:1]};
    code_held++;
    if (code_held == 8) begin
      put_code_byte(code_sr);
      code_sr   = '0;
      code_held = 0;
    end
  endfunction

  function automatic void emit_coded(bit b);
    shift_bit(b);
    while (pend_cnt > 0) begin
      shift_bit(!b);
      pend_cnt--;
    end
  endfunction

  function automatic void bump_pending();
    if (pend_cnt < PEND_MAX) pend_cnt++;
  endfunction

  // returns 0 for an ignored symbol, queues the bytes when keep is set
  function automatic bit encode_item(bit fin, logic [13:0] cl, logic [13:0] ch,
                                     logic [13:0] ct, bit keep);
    longint unsigned rng;
    longint unsigned up;
    longint unsigned dn;
    logic [16:0]     lo;
    logic [16:0]     hi;
    int              s;
    item_bytes.delete();
    if (fin) begin
      bump_pending();
      emit_coded(iv_low >= QTR_VAL);
      if (code_held > 0) put_code_byte(code_sr >> (8 - code_held));
      reset_model();
    end else begin
      if (ct == 0 || ch <= cl || ch > ct) return 1'b0;
      rng = 64'(iv_high) - 64'(iv_low) + 64'd1;
      up  = (rng * 64'(ch)) / 64'(ct);
      dn  = (rng * 64'(cl)) / 64'(ct);
      if (up <= dn) return 1'b0;
      hi = 17'(64'(iv_low) + up - 64'd1);
      lo = 17'(64'(iv_low) + dn);
      for (s = 0; s < CODE_W; s++) begin
        if (hi < HALF_VAL) begin
          emit_coded(1'b0);
        end else if (lo >= HALF_VAL) begin
          emit_coded(1'b1);
          lo = lo - HALF_VAL;
          hi = hi - HALF_VAL;
        end else if (lo >= QTR_VAL && hi < TQTR_VAL) begin
          bump_pending();
          lo = lo - QTR_VAL;
          hi = hi - QTR_VAL;
        end else begin
          break;
        end
        lo = (lo << 1) & TOP_VAL;
        hi = ((hi << 1) | 17'd1) & TOP_VAL;
      end
      iv_low  = lo;
      iv_high = hi;
    end
    if (keep) begin
      foreach (item_bytes[i]) coded_q.push_back({item_bytes[i], i == item_bytes.size() - 1});
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_item(input bit fin, input logic [13:0] cl, input logic [13:0] ch,
                           input logic [13:0] ct, input bit typed, input bit has_byte,
                           input logic [7:0] byte_val, output bit took);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, ct, ch, cl};
    s_axis_tuser  <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (typed) begin
      took = encode_item(fin, cl, ch, ct, 1'b0);
      if (has_byte) coded_q.push_back({byte_val, 1'b1});
    end else begin
      took = encode_item(fin, cl, ch, ct, 1'b1);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 8);
    end
  endtask

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(5, 60);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        m_axis_tready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  always @(posedge clk) begin : check_out
    code_byte_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (coded_q.size() == 0) begin
        report_mismatch("unexpected byte", m_axis_tdata, 8'h00);
      end else begin
        want = coded_q.pop_front();
        if (m_axis_tdata !== want.data) report_mismatch("out_byte", m_axis_tdata, want.data);
        if (m_axis_tlast !== want.last) begin
          report_mismatch("last", {7'b0, m_axis_tlast}, {7'b0, want.last});
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stim
    int          counted;
    int          r;
    bit          took;
    bit          fin;
    logic [13:0] cl;
    logic [13:0] ch;
    logic [13:0] ct;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    m_axis_tready <= 1'b0;
    reset_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].fin, dir_tab[i].cl, dir_tab[i].ch, dir_tab[i].ct,
                dir_tab[i].typed, dir_tab[i].has_byte, dir_tab[i].byte_val, took);
    end

    counted = 0;
    while (counted < RAND_ITEMS) begin
      r   = $urandom_range(0, 99);
      fin = 1'b0;
      cl  = 14'($urandom);
      ch  = 14'($urandom);
      ct  = 14'($urandom);
      if (r < 8) begin
        // raw fields, mostly bad symbols
      end else if (r < 16) begin
        fin = 1'b1;
      end else if (r < 21) begin
        ct = 14'($urandom_range(8192, 16383));
        cl = ct >> 1;
        ch = cl + 14'd1;
      end else begin
        case ($urandom_range(0, 3))
          0:       ct = 14'($urandom_range(1, 64));
          1:       ct = 14'h3FFF;
          default: ct = 14'($urandom_range(1, 16383));
        endcase
        cl = 14'($urandom_range(0, ct - 1));
        ch = ($urandom_range(0, 1) == 0) ? cl + 14'd1 : 14'($urandom_range(cl + 1, ct));
      end
      send_item(fin, cl, ch, ct, 1'b0, 1'b0, 8'h00, took);
      if (took) counted++;
    end

    s_axis_tvalid <= 1'b0;
    while (coded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
